/* src/feistel_block_cipher_31_rounds_macros.svh */
// assertion macros shared by the cipher rtl
`ifndef FEISTEL_BLOCK_CIPHER_31_ROUNDS_MACROS_SVH
`define FEISTEL_BLOCK_CIPHER_31_ROUNDS_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define FBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fbc31 assertion failed");
// checked during reset as well
`define FBC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("fbc31 reset assertion failed");
`else
`define FBC_ASSERT(lbl, prop)
`define FBC_ASSERT_RST(lbl, prop)
`endif

`endif

/* src/fbc31_pkg.sv */
package fbc31_pkg;

    localparam int BLOCK_W     = 64;
    localparam int HALF_W      = 32;
    localparam int KEY_W       = 128;
    localparam int KEYREG_W    = 64;
    localparam int RND_W       = 5;
    localparam int ROUND_COUNT = 31;
    localparam int ROT_HI      = 3;
    localparam int ROT_LO      = 7;
    localparam int KEY_ROT     = 13;
    localparam int CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'd1;

    // per-stage handshake control
    typedef struct packed {
        logic load;
        logic valid;
    } t_stg_ctl;

    // 4-bit substitution
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] r;
        case (x)
            4'h0: r = 4'h3;
            4'h1: r = 4'hf;
            4'h2: r = 4'he;
            4'h3: r = 4'h1;
            4'h4: r = 4'h0;
            4'h5: r = 4'ha;
            4'h6: r = 4'h5;
            4'h7: r = 4'h8;
            4'h8: r = 4'hc;
            4'h9: r = 4'h4;
            4'ha: r = 4'hb;
            4'hb: r = 4'h2;
            4'hc: r = 4'h9;
            4'hd: r = 4'h7;
            4'he: r = 4'h6;
            default: r = 4'hd;
        endcase
        return r;
    endfunction

    // substitute every nibble of a half word
    function automatic logic [HALF_W-1:0] sub_word(input logic [HALF_W-1:0] w);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int i = 0; i < HALF_W / 4; i++) begin
            r[i*4 +: 4] = sbox(w[i*4 +: 4]);
        end
        return r;
    endfunction

endpackage

/* src/feistel_block_cipher_31_rounds.sv */
// 64-bit block cipher, 128-bit key, one feistel round per pipeline stage.
// config port: i_cfg_wr_en writes i_cfg_data to the register selected by
// i_cfg_idx (0 = key_high, 1 = key_low) at the clock edge. write the key only
// while no transaction is in flight; each block latches the key on entry.
// input channel: i_valid / o_stall with i_plaintext; a transaction is taken
// at an edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with o_ciphertext, held while stalled.
// pipeline: one register stage per round carries block, expanded key and a
// valid bit.
// throughput: one block per cycle while the receiver does not stall.
// stall: each stage advances when it is empty or the stage after it moves,
// so bubbles are squeezed out; o_stall rises only when every stage is full
// and i_stall is high. nothing is dropped or duplicated.
// reset (synchronous, active low): all stage valid bits clear and both key
// registers return to zero.
`include "feistel_block_cipher_31_rounds_macros.svh"

module feistel_block_cipher_31_rounds #(
    parameter int ROUND_COUNT = fbc31_pkg::ROUND_COUNT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [fbc31_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbc31_pkg::KEYREG_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [fbc31_pkg::BLOCK_W-1:0]        i_plaintext,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [fbc31_pkg::BLOCK_W-1:0]        o_ciphertext
);

    logic [fbc31_pkg::KEYREG_W-1:0] r_key_high;
    logic [fbc31_pkg::KEYREG_W-1:0] r_key_low;

    logic [ROUND_COUNT-1:0]         w_valid;
    logic [ROUND_COUNT:0]           w_ready;
    logic [fbc31_pkg::BLOCK_W-1:0]  w_state [ROUND_COUNT];
    logic [fbc31_pkg::KEY_W-1:0]    w_key   [ROUND_COUNT];

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                fbc31_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                fbc31_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain, from the output back to the input
    always_comb begin
        w_ready[ROUND_COUNT] = !i_stall;
        for (int k = ROUND_COUNT - 1; k >= 0; k--) begin
            w_ready[k] = !w_valid[k] || w_ready[k+1];
        end
    end

    assign o_stall = !w_ready[0];

    // round stages
    for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
        fbc31_pkg::t_stg_ctl w_ctl;
        logic                          w_in_valid;
        logic [fbc31_pkg::BLOCK_W-1:0] w_in_state;
        logic [fbc31_pkg::KEY_W-1:0]   w_in_key;

        if (k == 0) begin : g_first
            assign w_in_valid  = i_valid;
            assign w_in_state  = i_plaintext;
            assign w_in_key    = {r_key_high, r_key_low};
        end else begin : g_next
            assign w_in_valid  = w_valid[k-1];
            assign w_in_state  = w_state[k-1];
            assign w_in_key    = w_key[k-1];
        end
        assign w_ctl = '{load: w_ready[k], valid: w_in_valid};

        fbc31_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_rnd   (fbc31_pkg::RND_W'(k)),
            .i_state (w_in_state),
            .i_key   (w_in_key),
            .o_valid (w_valid[k]),
            .o_state (w_state[k]),
            .o_key   (w_key[k])
        );
    end

    assign o_valid      = w_valid[ROUND_COUNT-1];
    assign o_ciphertext = w_state[ROUND_COUNT-1];

    // a result leaves only through a completed output transaction
    `FBC_ASSERT(a_out_leaves_on_xfer, $fell(o_valid) |-> $past(!i_stall))
    // an accepted block lands in the first stage
    `FBC_ASSERT(a_in_lands, (i_valid && !o_stall) |=> w_valid[0])
    // input is only held off when the whole pipeline is full
    `FBC_ASSERT(a_stall_full, o_stall |-> (&w_valid) && i_stall)
    // reset empties the pipeline
    `FBC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid && !w_valid[0])

endmodule

/* src/fbc31_stage.sv */
module fbc31_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fbc31_pkg::t_stg_ctl                  i_ctl,
    input  logic [fbc31_pkg::RND_W-1:0]          i_rnd,
    input  logic [fbc31_pkg::BLOCK_W-1:0]        i_state,
    input  logic [fbc31_pkg::KEY_W-1:0]          i_key,
    output logic                                 o_valid,
    output logic [fbc31_pkg::BLOCK_W-1:0]        o_state,
    output logic [fbc31_pkg::KEY_W-1:0]          o_key
);

    localparam int HW = fbc31_pkg::HALF_W;
    localparam int KW = fbc31_pkg::KEYREG_W;
    localparam int KR = fbc31_pkg::KEY_ROT;

    logic                              r_valid;
    logic [fbc31_pkg::BLOCK_W-1:0]     r_state;
    logic [fbc31_pkg::KEY_W-1:0]       r_key;
    logic [fbc31_pkg::BLOCK_W-1:0]     n_state;
    logic [fbc31_pkg::KEY_W-1:0]       n_key;

    logic [HW-1:0] w_hi;
    logic [HW-1:0] w_lo;
    logic [HW-1:0] w_s;
    logic [HW-1:0] w_nh_pre;
    logic [HW-1:0] w_nh;
    logic [HW-1:0] w_nl_pre;
    logic [HW-1:0] w_nl;
    logic [KW-1:0] w_kh;
    logic [KW-1:0] w_kl;
    logic [KW-1:0] w_th;
    logic [KW-1:0] w_tl;

    // one feistel round on the data half
    always_comb begin
        w_hi     = i_state[2*HW-1:HW];
        w_lo     = i_state[HW-1:0];
        w_kh     = i_key[2*KW-1:KW];
        w_kl     = i_key[KW-1:0];
        w_s      = fbc31_pkg::sub_word(w_hi);
        w_nh_pre = w_s ^ w_kl[HW-1:0] ^ w_lo;
        w_nh     = {w_nh_pre[HW-1-fbc31_pkg::ROT_HI:0],
                    w_nh_pre[HW-1:HW-fbc31_pkg::ROT_HI]};
        w_nl_pre = w_s ^ w_nh ^ w_kl[2*HW-1:HW];
        w_nl     = {w_nl_pre[fbc31_pkg::ROT_LO-1:0],
                    w_nl_pre[HW-1:fbc31_pkg::ROT_LO]};
        n_state  = {w_nh, w_nl};
    end

    // key schedule: rotate, substitute low byte, inject round number
    always_comb begin
        w_th = {w_kh[KW-1-KR:0], w_kl[KW-1:KW-KR]};
        w_tl = {w_kl[KW-1-KR:0], w_kh[KW-1:KW-KR]};
        w_tl[7:4] = fbc31_pkg::sbox(w_tl[7:4]);
        w_tl[3:0] = fbc31_pkg::sbox(w_tl[3:0]);
        w_tl[KW-1:KW-fbc31_pkg::RND_W] = w_tl[KW-1:KW-fbc31_pkg::RND_W] ^ i_rnd;
        n_key = {w_th, w_tl};
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_ctl.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_ctl.valid) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule
